[design/ppm_frame_pulse_generator_core_macros.svh]
// Assertion macros shared by the RTL that checks itself.
`ifndef PPM_FRAME_PULSE_GENERATOR_CORE_MACROS_SVH
`define PPM_FRAME_PULSE_GENERATOR_CORE_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define PPM_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define PPM_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("next-cycle check failed");

`endif

[design/ppm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ppm_pkg;

    // Frame geometry
    localparam int GAP_OFFSET = 9;
    localparam int END_TICKS  = 2;
    localparam int VALUE_MIN  = -8;
    localparam int VALUE_MAX  = 8;

    // Widths
    localparam int VALUE_W = 5;
    localparam int GAP_W   = 5;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    typedef logic [1:0]                slot_t;
    typedef logic signed [VALUE_W-1:0] chan_val_t;
    typedef logic [GAP_W-1:0]          gap_t;

    // Slot after the three channels
    localparam slot_t END_SLOT = 2'd3;

    // Register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_FIRST  = 2'd0,
        REG_SECOND = 2'd1,
        REG_THIRD  = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    // Channel sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_HIGH      = 2'd1,
        PH_FIRST_LOW = 2'd2,
        PH_COUNT     = 2'd3
    } phase_t;

    // One output item
    typedef struct packed {
        logic  level;
        slot_t slot;
    } result_t;

    // Gap length for a channel value; out-of-range values close after one low tick
    function automatic gap_t gap_threshold(input chan_val_t value);
        gap_t thr;
        if (int'(value) < VALUE_MIN || int'(value) > VALUE_MAX) begin
            thr = gap_t'(1);
        end
        else begin
            thr = gap_t'(int'(value) + GAP_OFFSET);
        end
        return thr;
    endfunction

endpackage

`default_nettype wire

[design/ppm_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ppm_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

[design/ppm_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ppm_out_if;
    logic           valid;
    logic           ready;
    logic           level;
    ppm_pkg::slot_t slot;

    modport source (output valid, output level, output slot, input ready);
    modport sink   (input valid, input level, input slot, output ready);
endinterface

`default_nettype wire

[design/ppm_frame_pulse_generator_core.sv]
// A tick item's level and slot are registered in the output register, or in the skid entry while the output stalls.
// Throughput: one item per cycle while the skid entry is free; the sequencer state updates in the accepting cycle.
// A two-entry output buffer keeps input ready high for one extra item while
// the output side stalls.
// Reset (rst_n low, asynchronous): sequencer at channel 0 idle, channel values 0,
// output buffer empty.
`timescale 1ns / 1ps
`default_nettype none

`include "ppm_frame_pulse_generator_core_macros.svh"

module ppm_frame_pulse_generator_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    ppm_in_if.sink                            in_ch,
    ppm_out_if.source                         out_ch,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ppm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ppm_pkg::DATA_W-1:0]   pwdata,
    output logic      [ppm_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);

    import ppm_pkg::*;

    // Configuration registers
    chan_val_t first_reg;
    chan_val_t second_reg;
    chan_val_t third_reg;
    reg_idx_t  reg_idx;
    logic      cfg_write;

    // Sequencer state
    slot_t  slot_reg,  slot_next;
    phase_t phase_reg, phase_next;
    gap_t   gap_reg,   gap_next;

    // Working values for the current tick
    slot_t     slot_eff;
    phase_t    phase_eff;
    gap_t      gap_eff;
    gap_t      gap_inc;
    gap_t      thr;
    chan_val_t sel_value;
    slot_t     slot_inc;
    result_t   result;
    logic      in_accept;

    // Output buffer
    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    // APB access
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            first_reg  <= '0;
            second_reg <= '0;
            third_reg  <= '0;
        end
        else if (cfg_write) begin
            unique case (reg_idx)
                REG_FIRST:  first_reg  <= chan_val_t'(pwdata[VALUE_W-1:0]);
                REG_SECOND: second_reg <= chan_val_t'(pwdata[VALUE_W-1:0]);
                REG_THIRD:  third_reg  <= chan_val_t'(pwdata[VALUE_W-1:0]);
                default:    ;
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        unique case (reg_idx)
            REG_FIRST:  prdata = {{(DATA_W-VALUE_W){1'b0}}, first_reg};
            REG_SECOND: prdata = {{(DATA_W-VALUE_W){1'b0}}, second_reg};
            REG_THIRD:  prdata = {{(DATA_W-VALUE_W){1'b0}}, third_reg};
            default:    prdata = '0;
        endcase
    end

    // Take an item whenever the skid entry is free
    assign in_ch.ready = !skid_valid_reg;
    assign in_accept   = in_ch.valid && in_ch.ready;

    // Hold sequencer state between accepted ticks
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            slot_reg  <= '0;
            phase_reg <= PH_IDLE;
            gap_reg   <= '0;
        end
        else if (in_accept) begin
            slot_reg  <= slot_next;
            phase_reg <= phase_next;
            gap_reg   <= gap_next;
        end
    end

    // Clear the sequencer view on restart
    assign slot_eff  = in_ch.restart ? slot_t'(0) : slot_reg;
    assign phase_eff = in_ch.restart ? PH_IDLE    : phase_reg;
    assign gap_eff   = in_ch.restart ? gap_t'(0)  : gap_reg;

    // Pick the gap length of the current channel
    always_comb begin
        unique case (slot_eff)
            2'd0:    sel_value = first_reg;
            2'd1:    sel_value = second_reg;
            default: sel_value = third_reg;
        endcase
        thr = gap_threshold(sel_value);
    end

    // Advance the sequencer by one tick
    always_comb begin
        gap_inc   = gap_eff + gap_t'(1);
        slot_inc  = slot_eff + slot_t'(1);

        slot_next    = slot_eff;
        phase_next   = phase_eff;
        gap_next     = gap_eff;
        result.level = 1'b0;

        if (slot_eff == END_SLOT) begin
            // Ending marker: high ticks, then wrap to channel 0
            gap_next     = gap_inc;
            result.level = 1'b1;
            if (gap_inc >= gap_t'(END_TICKS)) begin
                slot_next = '0;
            end
        end
        else begin
            unique case (phase_eff) inside
                PH_IDLE: begin
                    phase_next   = PH_HIGH;
                    result.level = 1'b1;
                end
                PH_HIGH: begin
                    phase_next = PH_FIRST_LOW;
                    gap_next   = '0;
                end
                PH_FIRST_LOW, PH_COUNT: begin
                    if (gap_inc >= thr) begin
                        // Gap closed: next channel's high tick, or the ending marker
                        slot_next    = slot_inc;
                        gap_next     = '0;
                        result.level = 1'b1;
                        phase_next   = (slot_inc == END_SLOT) ? PH_IDLE : PH_HIGH;
                    end
                    else begin
                        gap_next   = gap_inc;
                        phase_next = PH_COUNT;
                    end
                end
                default: ;
            endcase
        end

        result.slot = slot_next;
    end

    // Output register with a skid entry behind it
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ch.ready) begin
            if (in_accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= in_accept;
        end
    end

    // Payload moves without reset
    always_ff @(posedge clk) begin
        if (out_valid_reg && !out_ch.ready) begin
            if (in_accept) begin
                skid_reg <= result;
            end
        end
        else if (skid_valid_reg) begin
            out_reg <= skid_reg;
        end
        else if (in_accept) begin
            out_reg <= result;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.level = out_reg.level;
    assign out_ch.slot  = out_reg.slot;

    // Checks
    `PPM_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `PPM_ASSERT_NEXT(a_stall_fills_skid, out_valid_reg && !out_ch.ready && in_accept,
                     skid_valid_reg)
    `PPM_ASSERT_SAME(a_end_marker_short, slot_reg == END_SLOT, gap_reg < gap_t'(END_TICKS))

endmodule

`default_nettype wire

[verif/tb_ppm_frame_pulse_generator_core.sv]
`timescale 1ns / 1ps

module tb_ppm_frame_pulse_generator_core;
    import ppm_pkg::*;

    // Track the frame sequencer and hold the pulse levels still to arrive
    class frame_scoreboard;
        chan_val_t chan_value [3] = '{default: '0};
        slot_t     cur_slot       = '0;
        phase_t    cur_phase      = PH_IDLE;
        gap_t      low_count      = '0;
        result_t   pulse_queue [$];
        int        errors         = 0;

        function void set_channel(input reg_idx_t idx, input chan_val_t value);
            chan_value[idx] = value;
        endfunction

        // Low ticks in a channel's gap; values off the nominal range close after one low tick
        function int gap_length(input chan_val_t value);
            int v;
            v = int'(value);
            if (v >= VALUE_MIN && v <= VALUE_MAX)
            begin
                return v + GAP_OFFSET;
            end
            return 1;
        endfunction

        // Advance the sequencer by one tick and queue the level it gives
        function void note_tick(input logic restart);
            result_t pulse;
            bit      settled;
            settled = 1'b0;
            pulse.level = 1'b0;
            if (restart)
            begin
                cur_slot  = '0;
                cur_phase = PH_IDLE;
                low_count = '0;
            end
            if (cur_slot == END_SLOT)
            begin
                low_count = low_count + 1'b1;
                if (int'(low_count) >= END_TICKS)
                begin
                    cur_slot = '0;
                end
                pulse.level = 1'b1;
            end
            else
            begin
                while (!settled)
                begin
                    if (cur_phase != PH_COUNT)
                    begin
                        cur_phase = phase_t'(cur_phase + 2'd1);
                    end
                    case (cur_phase)
                        PH_HIGH:
                        begin
                            pulse.level = 1'b1;
                            settled = 1'b1;
                        end
                        PH_FIRST_LOW:
                        begin
                            pulse.level = 1'b0;
                            low_count = '0;
                            settled = 1'b1;
                        end
                        default:
                        begin
                            low_count = low_count + 1'b1;
                            if (int'(low_count) >= gap_length(chan_value[cur_slot]))
                            begin
                                // close the gap; the next channel's high tick falls here too
                                cur_phase = PH_IDLE;
                                low_count = '0;
                                cur_slot = cur_slot + 1'b1;
                                if (cur_slot == END_SLOT)
                                begin
                                    pulse.level = 1'b1;
                                    settled = 1'b1;
                                end
                            end
                            else
                            begin
                                pulse.level = 1'b0;
                                settled = 1'b1;
                            end
                        end
                    endcase
                end
            end
            pulse.slot = cur_slot;
            pulse_queue.push_back(pulse);
        endfunction

        function void check_result(input logic level, input slot_t slot);
            result_t want;
            if (pulse_queue.size() == 0)
            begin
                $error("pulse output with no tick waiting: level %0d slot %0d", level, slot);
                errors++;
                return;
            end
            want = pulse_queue.pop_front();
            if (level !== want.level)
            begin
                $error("level mismatch: expected %0d actual %0d", want.level, level);
                errors++;
            end
            if (slot !== want.slot)
            begin
                $error("slot mismatch: expected %0d actual %0d", want.slot, slot);
                errors++;
            end
        endfunction

        function int pending();
            return pulse_queue.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    bit                   in_bursty;
    bit                   out_bursty;
    bit                   squeeze_req;

    frame_scoreboard      sb = new;

    ppm_in_if  in_ch ();
    ppm_out_if out_ch ();

    ppm_frame_pulse_generator_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 125 MHz clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                sb.note_tick(in_ch.restart);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                sb.check_result(out_ch.level, out_ch.slot);
            end
        end
    end

    // Drive output ready: random stall bursts plus one long hold on request
    initial
    begin : receiver
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                hold = 80;
            end
            if (hold > 0)
            begin
                out_ch.ready <= 1'b0;
                hold = hold - 1;
            end
            else if (out_bursty && $urandom_range(0, 11) == 0)
            begin
                out_ch.ready <= 1'b0;
                hold = $urandom_range(1, 13) - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Write one channel register over the APB port
    task automatic write_reg(input reg_idx_t idx, input chan_val_t value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(DATA_W - VALUE_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        sb.set_channel(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one tick item and hold it until accepted, then maybe idle
    task automatic send_tick(input logic restart);
        int gap;
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.restart <= restart;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        if (in_bursty && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid and drain every pending pulse
    task automatic settle();
        int guard;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (3) @(posedge clk);
    endtask

    // Load the three channels, then run random ticks with rare restarts
    task automatic run_phase(input chan_val_t v0, input chan_val_t v1, input chan_val_t v2,
                             input int count, input bit squeeze);
        int k;
        write_reg(REG_FIRST, v0);
        write_reg(REG_SECOND, v1);
        write_reg(REG_THIRD, v2);
        for (k = 0; k < count; k++)
        begin
            if (squeeze && k == 30)
            begin
                squeeze_req = 1'b1;
            end
            send_tick($urandom_range(0, 39) == 0);
        end
        settle();
    endtask

    function automatic chan_val_t nominal_value();
        return chan_val_t'(int'($urandom_range(0, 16)) - 8);
    endfunction

    initial
    begin : stimulus
        int i;
        int p;
        in_ch.valid   = 1'b0;
        in_ch.restart = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rst_n         = 1'b0;
        in_bursty     = 1'b0;
        out_bursty    = 1'b0;
        squeeze_req   = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset channel values, one restart mid gap
        in_bursty  = 1'b1;
        out_bursty = 1'b1;
        for (i = 0; i < 40; i++)
        begin
            send_tick(i == 20);
        end
        settle();

        // Shortest gaps: full frames, restarts at start, in the marker and back to back
        write_reg(REG_FIRST, chan_val_t'(VALUE_MIN));
        write_reg(REG_SECOND, chan_val_t'(VALUE_MIN));
        write_reg(REG_THIRD, chan_val_t'(VALUE_MIN));
        for (i = 0; i < 24; i++)
        begin
            send_tick(i == 0 || i == 8 || i == 12 || i == 13 || i == 20);
        end
        settle();

        // Longest gaps, mixed extremes with the long output hold, then varied settings
        run_phase(chan_val_t'(VALUE_MAX), chan_val_t'(VALUE_MAX), chan_val_t'(VALUE_MAX),
                  175, 1'b0);
        run_phase(chan_val_t'(VALUE_MIN), chan_val_t'(0), chan_val_t'(VALUE_MAX), 175, 1'b1);
        for (p = 0; p < 5; p++)
        begin
            in_bursty  = ($urandom_range(0, 2) != 0);
            out_bursty = ($urandom_range(0, 2) != 0);
            case (p)
                0: run_phase(nominal_value(), nominal_value(), nominal_value(), 175, 1'b0);
                1: run_phase(chan_val_t'(-16), chan_val_t'(9), chan_val_t'(15), 175, 1'b0);
                2: run_phase(chan_val_t'($urandom_range(0, 31)), chan_val_t'($urandom_range(0, 31)),
                             chan_val_t'($urandom_range(0, 31)), 175, 1'b0);
                3: run_phase(nominal_value(), nominal_value(), nominal_value(), 175, 1'b0);
                default: run_phase(chan_val_t'(VALUE_MAX), chan_val_t'(VALUE_MIN),
                                   chan_val_t'(-1), 175, 1'b0);
            endcase
        end

        // Closing stretch with no idling on either side
        in_bursty  = 1'b0;
        out_bursty = 1'b0;
        run_phase(nominal_value(), nominal_value(), nominal_value(), 175, 1'b0);

        if (sb.pending() != 0)
        begin
            $error("%0d pulse outputs never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("tb_ppm_frame_pulse_generator_core passed");
        end
        else
        begin
            $display("tb_ppm_frame_pulse_generator_core failed");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #5_000_000;
        $display("tb_ppm_frame_pulse_generator_core failed");
        $finish;
    end

endmodule

[ppm_frame_pulse_generator_core.f]
+incdir+design
design/ppm_pkg.sv
design/ppm_in_if.sv
design/ppm_out_if.sv
design/ppm_frame_pulse_generator_core.sv
verif/tb_ppm_frame_pulse_generator_core.sv
